// ===== sv/prrs_pkg.sv =====
package prrs_pkg;

  localparam int NUM_ENTRIES = 25;
  localparam int ENTRY_W     = $clog2(NUM_ENTRIES);
  localparam int IDX_W       = 5;
  localparam int CNT_W       = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CNT_W-1:0] RETRY_LIMIT_RST = 8'd3;
  localparam logic [CNT_W-1:0] RETRY_GAP_RST   = 8'd20;
  localparam logic [IDX_W-1:0] PERSIST_RST     = 5'd6;

  // Entries below this index are response entries, cleared as soon as they are sent.
  localparam logic [IDX_W-1:0] NUM_RESPONSE = 5'd2;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_RAISE = 2'd1,
    FUNC_ACK   = 2'd2,
    FUNC_SLOT  = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RETRY_LIMIT = 2'd0,
    CFG_RETRY_GAP   = 2'd1,
    CFG_PERSIST     = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    LINK_NONE = 2'd0,
    LINK_OK   = 2'd1,
    LINK_FAIL = 2'd2
  } link_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

  // Lowest set flag, or zero when none is set.
  function automatic logic [IDX_W-1:0] lowest_pending(input logic [NUM_ENTRIES-1:0] flags);
    logic [IDX_W-1:0] idx;
    logic             found;
    idx   = '0;
    found = 1'b0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (flags[i] && !found) begin
        idx   = IDX_W'(i);
        found = 1'b1;
      end
    end
    return idx;
  endfunction

endpackage

// ===== sv/prrs_ctrl.sv =====
module prrs_ctrl
  import prrs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  output dp_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy     = 1'b0;
    cmd.load = 1'b0;
    cmd.exec = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cmd.load = start;
      end
      ST_EXEC: begin
        busy     = 1'b1;
        cmd.exec = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

// ===== sv/prrs_dp.sv =====
module prrs_dp
  import prrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  input  logic [1:0]            in_func,
  input  logic [IDX_W-1:0]      in_request_index,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_valid,
  output logic                  out_sent,
  output logic [IDX_W-1:0]      out_sent_id,
  output logic                  out_is_retry,
  output logic [1:0]            out_link_status,
  output logic                  out_busy_res
);

  logic [CNT_W-1:0]       retry_limit_r, retry_gap_r;
  logic [IDX_W-1:0]       persist_r;

  logic [1:0]             func_r;
  logic [IDX_W-1:0]       req_r;

  logic [NUM_ENTRIES-1:0] pending_r, pending_nxt;
  logic [IDX_W-1:0]       cur_r, cur_nxt;
  logic                   flight_r, flight_nxt;
  logic [CNT_W-1:0]       retries_r, retries_nxt;
  logic [CNT_W-1:0]       gap_r, gap_nxt;

  logic                   sent_nxt, retry_nxt;
  logic [IDX_W-1:0]       sent_id_nxt;
  logic [1:0]             link_nxt;
  logic [IDX_W-1:0]       lowest;

  logic                   valid_r;
  logic                   sent_r, retry_r, busy_res_r;
  logic [IDX_W-1:0]       sent_id_r;
  logic [1:0]             link_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r <= RETRY_LIMIT_RST;
      retry_gap_r   <= RETRY_GAP_RST;
      persist_r     <= PERSIST_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RETRY_LIMIT: retry_limit_r <= cfg_wdata[CNT_W-1:0];
        CFG_RETRY_GAP:   retry_gap_r   <= cfg_wdata[CNT_W-1:0];
        CFG_PERSIST:     persist_r     <= cfg_wdata[IDX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The word is captured on acceptance and executed in the following cycle.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      req_r  <= in_request_index;
    end
  end

  assign lowest = lowest_pending(pending_r);

  always_comb begin
    pending_nxt = pending_r;
    cur_nxt     = cur_r;
    flight_nxt  = flight_r;
    retries_nxt = retries_r;
    gap_nxt     = gap_r;
    sent_nxt    = 1'b0;
    sent_id_nxt = '0;
    retry_nxt   = 1'b0;
    link_nxt    = LINK_NONE;
    case (func_r)
      FUNC_TICK: begin
        if (gap_r != '0) begin
          gap_nxt = gap_r - 1'b1;
        end
      end
      FUNC_RAISE: begin
        if (32'(req_r) < NUM_ENTRIES) begin
          pending_nxt[req_r[ENTRY_W-1:0]] = 1'b1;
        end
      end
      FUNC_ACK: begin
        link_nxt = LINK_OK;
        if (flight_r) begin
          pending_nxt[cur_r[ENTRY_W-1:0]] = 1'b0;
          flight_nxt                      = 1'b0;
        end
      end
      FUNC_SLOT: begin
        if (flight_r) begin
          if (gap_r == '0) begin
            gap_nxt     = retry_gap_r;
            retries_nxt = (retries_r != '0) ? retries_r - 1'b1 : retries_r;
            if (retries_nxt == '0 && cur_r != persist_r) begin
              pending_nxt[cur_r[ENTRY_W-1:0]] = 1'b0;
              flight_nxt                      = 1'b0;
              link_nxt                        = LINK_FAIL;
            end else begin
              sent_nxt    = 1'b1;
              sent_id_nxt = cur_r;
              retry_nxt   = 1'b1;
            end
          end
        end else if (pending_r != '0) begin
          cur_nxt     = lowest;
          sent_nxt    = 1'b1;
          sent_id_nxt = lowest;
          if (lowest < NUM_RESPONSE) begin
            pending_nxt[lowest[ENTRY_W-1:0]] = 1'b0;
          end else begin
            flight_nxt = 1'b1;
          end
          gap_nxt     = retry_gap_r;
          retries_nxt = retry_limit_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      cur_r     <= '0;
      flight_r  <= 1'b0;
      retries_r <= RETRY_LIMIT_RST;
      gap_r     <= RETRY_GAP_RST;
      valid_r   <= 1'b0;
    end else begin
      valid_r <= cmd.exec;
      if (cmd.exec) begin
        pending_r <= pending_nxt;
        cur_r     <= cur_nxt;
        flight_r  <= flight_nxt;
        retries_r <= retries_nxt;
        gap_r     <= gap_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      sent_r     <= sent_nxt;
      sent_id_r  <= sent_id_nxt;
      retry_r    <= retry_nxt;
      link_r     <= link_nxt;
      busy_res_r <= flight_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign out_sent        = sent_r;
  assign out_sent_id     = sent_id_r;
  assign out_is_retry    = retry_r;
  assign out_link_status = link_r;
  assign out_busy_res    = busy_res_r;

endmodule

// ===== sv/priority_report_retry_scheduler.sv =====
// Report scheduler with retry: a word is accepted when start is high and busy is low, is
// executed in the next cycle, and its result appears on the out_ ports for exactly one
// cycle, marked by out_valid, in the cycle after that. The receiver cannot stall, so the
// result must be taken when shown. Each word goes through the controller's capture and
// execute sequence; busy is low again while the result is shown, so a new word can be
// accepted in that cycle. Configuration writes take effect at once and should be made
// only while idle.
module priority_report_retry_scheduler
  import prrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_func,
  input  logic [IDX_W-1:0]      in_request_index,
  output logic                  out_valid,
  output logic                  out_sent,
  output logic [IDX_W-1:0]      out_sent_id,
  output logic                  out_is_retry,
  output logic [1:0]            out_link_status,
  output logic                  out_busy_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t cmd;

  prrs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  prrs_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_func          (in_func),
    .in_request_index (in_request_index),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_sent         (out_sent),
    .out_sent_id      (out_sent_id),
    .out_is_retry     (out_is_retry),
    .out_link_status  (out_link_status),
    .out_busy_res     (out_busy_res)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not enter execution");

  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) && !busy)
    else $error("result strobe without a preceding execution cycle");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_sent |-> out_sent_id == '0 && !out_is_retry)
    else $error("sent id or retry flag set without a transmission");

  a_fail_drops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_link_status == LINK_FAIL |-> !out_sent && !out_busy_res)
    else $error("give-up left an entry in flight or transmitted");
`endif

endmodule

// ===== sim/retry_report_checker.sv =====
`timescale 1ns / 1ps

module retry_report_checker
  import prrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic [1:0]            in_func,
  input  logic [IDX_W-1:0]      in_request_index,
  input  logic                  out_valid,
  input  logic                  out_sent,
  input  logic [IDX_W-1:0]      out_sent_id,
  input  logic                  out_is_retry,
  input  logic [1:0]            out_link_status,
  input  logic                  out_busy_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatches,
  output int                    outstanding
);

  typedef struct packed {
    logic             sent;
    logic [IDX_W-1:0] sent_id;
    logic             is_retry;
    link_t            link;
    logic             busy_res;
  } report_t;

  // Register copies
  logic [CNT_W-1:0]       limit_reg;
  logic [CNT_W-1:0]       gap_reg;
  logic [IDX_W-1:0]       persist_reg;

  // Scheduler state as the block should hold it
  logic [NUM_ENTRIES-1:0] pending;
  logic [IDX_W-1:0]       current;
  logic                   flying;
  logic [CNT_W-1:0]       tries_left;
  logic [CNT_W-1:0]       gap_left;

  report_t expected_reports[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic advance_schedule(input func_t f, input logic [IDX_W-1:0] req,
                                  output report_t rep);
    logic [IDX_W-1:0] first;
    rep      = '0;
    rep.link = LINK_NONE;
    case (f)
      FUNC_TICK: begin
        if (gap_left != 0) gap_left = gap_left - 1'b1;
      end
      FUNC_RAISE: begin
        if (req < NUM_ENTRIES) pending[req] = 1'b1;
      end
      FUNC_ACK: begin
        rep.link = LINK_OK;
        if (flying) begin
          pending[current] = 1'b0;
          flying           = 1'b0;
        end
      end
      FUNC_SLOT: begin
        if (flying) begin
          if (gap_left == 0) begin
            gap_left = gap_reg;
            if (tries_left != 0) tries_left = tries_left - 1'b1;
            if (tries_left == 0 && current != persist_reg) begin
              pending[current] = 1'b0;
              flying           = 1'b0;
              rep.link         = LINK_FAIL;
            end else begin
              rep.sent     = 1'b1;
              rep.sent_id  = current;
              rep.is_retry = 1'b1;
            end
          end
        end else if (pending != '0) begin
          first = '0;
          for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
            if (pending[i]) first = IDX_W'(i);
          end
          current     = first;
          rep.sent    = 1'b1;
          rep.sent_id = first;
          // Response entries never wait for an acknowledge.
          if (first < NUM_RESPONSE) pending[first] = 1'b0;
          else flying = 1'b1;
          gap_left   = gap_reg;
          tries_left = limit_reg;
        end
      end
    endcase
    rep.busy_res = flying;
  endtask

  always @(posedge clk) begin
    report_t want;
    report_t next_rep;
    if (!rst_n) begin
      limit_reg   = RETRY_LIMIT_RST;
      gap_reg     = RETRY_GAP_RST;
      persist_reg = PERSIST_RST;
      pending     = '0;
      current     = '0;
      flying      = 1'b0;
      tries_left  = RETRY_LIMIT_RST;
      gap_left    = RETRY_GAP_RST;
      expected_reports.delete();
    end else begin
      if (out_valid) begin
        if (expected_reports.size() == 0) begin
          $error("result word with no expectation waiting");
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          if (out_sent !== want.sent) begin
            $error("sent: expected %0d, actual %0d", want.sent, out_sent);
            mismatches++;
          end
          if (out_sent_id !== want.sent_id) begin
            $error("sent_id: expected %0d, actual %0d", want.sent_id, out_sent_id);
            mismatches++;
          end
          if (out_is_retry !== want.is_retry) begin
            $error("is_retry: expected %0d, actual %0d", want.is_retry, out_is_retry);
            mismatches++;
          end
          if (out_link_status !== want.link) begin
            $error("link_status: expected %0d, actual %0d", want.link, out_link_status);
            mismatches++;
          end
          if (out_busy_res !== want.busy_res) begin
            $error("busy_res: expected %0d, actual %0d", want.busy_res, out_busy_res);
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_RETRY_LIMIT: limit_reg   = cfg_wdata;
          CFG_RETRY_GAP:   gap_reg     = cfg_wdata;
          CFG_PERSIST:     persist_reg = cfg_wdata[IDX_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        advance_schedule(func_t'(in_func), in_request_index, next_rep);
        expected_reports.push_back(next_rep);
      end
    end
    outstanding = expected_reports.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import prrs_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            in_func = FUNC_TICK;
  logic [IDX_W-1:0]      in_request_index = '0;
  logic                  out_valid;
  logic                  out_sent;
  logic [IDX_W-1:0]      out_sent_id;
  logic                  out_is_retry;
  logic [1:0]            out_link_status;
  logic                  out_busy_res;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_RETRY_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int mismatches;
  int outstanding;
  int quiet_cycles = 0;
  bit no_gaps = 1'b0;

  priority_report_retry_scheduler uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_request_index (in_request_index),
    .out_valid        (out_valid),
    .out_sent         (out_sent),
    .out_sent_id      (out_sent_id),
    .out_is_retry     (out_is_retry),
    .out_link_status  (out_link_status),
    .out_busy_res     (out_busy_res),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  retry_report_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_request_index (in_request_index),
    .out_valid        (out_valid),
    .out_sent         (out_sent),
    .out_sent_id      (out_sent_id),
    .out_is_retry     (out_is_retry),
    .out_link_status  (out_link_status),
    .out_busy_res     (out_busy_res),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  // start is left high so that a following word goes straight on.
  task automatic send_word(input func_t f, input logic [IDX_W-1:0] idx);
    in_func          <= f;
    in_request_index <= idx;
    start            <= 1'b1;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int roll;
    int len;
    roll = $urandom_range(0, 99);
    len  = 0;
    if (!no_gaps && roll >= 60) len = (roll < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (len > 0) begin
      start <= 1'b0;
      repeat (len) @(negedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (outstanding != 0 || busy) @(negedge clk);
  endtask

  task automatic write_regs(input logic [7:0] lim, input logic [7:0] gap,
                            input logic [7:0] pers);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RETRY_LIMIT;
    cfg_wdata <= lim;
    @(negedge clk);
    cfg_index <= CFG_RETRY_GAP;
    cfg_wdata <= gap;
    @(negedge clk);
    cfg_index <= CFG_PERSIST;
    cfg_wdata <= pers;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input logic [7:0] lim, input logic [7:0] gap,
                           input logic [7:0] pers, input int count);
    int    roll;
    func_t f;
    logic [IDX_W-1:0] idx;
    drain();
    write_regs(lim, gap, pers);
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 35) f = FUNC_TICK;
      else if (roll < 55) f = FUNC_RAISE;
      else if (roll < 65) f = FUNC_ACK;
      else f = FUNC_SLOT;
      // Raises mostly name a real entry; the rest draw any index, which may fall beyond the table.
      if (f == FUNC_RAISE && $urandom_range(0, 9) != 0) begin
        idx = IDX_W'($urandom_range(0, NUM_ENTRIES - 1));
      end else begin
        idx = IDX_W'($urandom_range(0, 31));
      end
      send_word(f, idx);
      idle_gap();
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: short gap so that retries, saturation and a give-up show quickly.
    drain();
    write_regs(8'd2, 8'd1, 8'd24);
    send_word(FUNC_SLOT, 5'd0);
    send_word(FUNC_ACK, 5'd0);
    send_word(FUNC_TICK, 5'd31);
    send_word(FUNC_RAISE, 5'd31);
    send_word(FUNC_RAISE, 5'd24);
    send_word(FUNC_RAISE, 5'd0);
    send_word(FUNC_RAISE, 5'd1);
    send_word(FUNC_RAISE, 5'd1);
    send_word(FUNC_SLOT, 5'd0);
    send_word(FUNC_SLOT, 5'd0);
    send_word(FUNC_SLOT, 5'd0);
    send_word(FUNC_SLOT, 5'd0);
    send_word(FUNC_TICK, 5'd0);
    send_word(FUNC_TICK, 5'd0);
    send_word(FUNC_SLOT, 5'd0);
    send_word(FUNC_TICK, 5'd0);
    send_word(FUNC_SLOT, 5'd0);
    send_word(FUNC_TICK, 5'd0);
    send_word(FUNC_SLOT, 5'd0);
    send_word(FUNC_ACK, 5'd0);
    send_word(FUNC_RAISE, 5'd3);
    send_word(FUNC_SLOT, 5'd0);
    send_word(FUNC_RAISE, 5'd3);
    send_word(FUNC_TICK, 5'd0);
    send_word(FUNC_SLOT, 5'd0);
    send_word(FUNC_TICK, 5'd0);
    send_word(FUNC_SLOT, 5'd0);

    run_phase(8'd3, 8'd20, 8'd6, 250);
    run_phase(8'd1, 8'd0, 8'd2, 250);
    run_phase(8'd255, 8'd1, 8'd24, 200);
    // A zero retry limit together with a persistent index beyond the table.
    run_phase(8'd0, 8'd2, 8'hFF, 200);
    // Persistent index on a response entry.
    run_phase(8'd2, 8'd255, 8'd0, 150);
    run_phase(8'd4, 8'd3, 8'($urandom_range(0, 31)), 200);
    run_phase(8'd255, 8'd255, 8'd3, 100);

    drain();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
